// ===== hw/rtl/frc_pkg.sv =====
// Shared constants for the range counter with mark-after-query.
// Used by frc_ram users and the top level; no dependencies.
`timescale 1ns / 1ps

package frc_pkg;

   // Number of tree positions, numbered from 1.
   localparam int MAX_POSITIONS = 1024;

   // Field widths, fixed by the interface.
   localparam int POSITION_W = 11;
   localparam int COUNT_W    = 16;

   // Tree memory address: position minus one.
   localparam int ADDR_W = $clog2(MAX_POSITIONS);

   // The index walk must hold any input position, any table position and
   // one step past either of them.
   localparam int SPAN_W = (POSITION_W > ADDR_W + 1) ? POSITION_W : ADDR_W + 1;
   localparam int WALK_W = SPAN_W + 1;

   localparam logic [POSITION_W-1:0] SIZE_RESET = POSITION_W'(1024);

endpackage

// ===== hw/rtl/fenwick_range_count_then_mark.sv =====
// Top level of the binary indexed range counter with mark-after-query.
// Depends on frc_pkg and frc_ram.
`timescale 1ns / 1ps

// Usage
// The request channel (req_valid, req_stall, req_range_low, req_range_high)
// takes one word per item. Each word yields exactly one response word on
// rsp_valid / rsp_stall / rsp_marked_count: the number of marks in
// [low, high] before this word's own mark, modulo 2^16. The block then marks
// position high, unless high is zero, above the size register or past 1024.
// csr_write_enable / csr_write_data set the size register (reset 1024); write
// it only while the block is idle.
// One item is worked at a time. The tree lives in one 1024 x 16 memory with
// a registered read, and each walk step issues at most one memory read per
// cycle. An item goes through accept, the walk for high, the walk for low - 1,
// the update walk and the output step. The next word is accepted once the
// response is loaded into the output register, even while that response is
// still stalled. After reset the block clears the memory, one entry a cycle,
// until all 1024 entries are zero, and holds req_stall high meanwhile. A
// stalled response holds its value, and the block waits in its last step
// until the output register frees.

module fenwick_range_count_then_mark (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [frc_pkg::POSITION_W-1:0] req_range_low,
   input  logic [frc_pkg::POSITION_W-1:0] req_range_high,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [frc_pkg::COUNT_W-1:0]    rsp_marked_count,
   input  logic                           csr_write_enable,
   input  logic [frc_pkg::POSITION_W-1:0] csr_write_data
);

   localparam int WALK_W = frc_pkg::WALK_W;
   localparam int ADDR_W = frc_pkg::ADDR_W;
   localparam int POS_W  = frc_pkg::POSITION_W;
   localparam int CNT_W  = frc_pkg::COUNT_W;
   localparam logic [WALK_W-1:0] TABLE_TOP = WALK_W'(frc_pkg::MAX_POSITIONS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(frc_pkg::MAX_POSITIONS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QHI,
      ST_QLO,
      ST_UPD,
      ST_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   lo_ff, lo_in;
   logic [POS_W-1:0]   hi_ff, hi_in;
   logic [WALK_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]   acc_ff, acc_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  upd_addr_ff, upd_addr_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [POS_W-1:0]   size_ff, size_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [CNT_W-1:0]   ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [CNT_W-1:0]   ram_rd_data;

   logic [WALK_W-1:0]  low_bit;
   logic [WALK_W-1:0]  pos_dec;
   logic [WALK_W-1:0]  size_ext;
   logic [WALK_W-1:0]  limit;
   logic               in_table;
   logic               rsp_free;

   frc_ram #(
      .WIDTH (CNT_W),
      .DEPTH (frc_pkg::MAX_POSITIONS)
   ) u_tree (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      low_bit  = pos_ff & (~pos_ff + WALK_W'(1));
      pos_dec  = pos_ff - WALK_W'(1);
      size_ext = WALK_W'(size_ff);
      limit    = (size_ext > TABLE_TOP) ? TABLE_TOP : size_ext;
      in_table = (pos_ff != '0) && (pos_ff <= TABLE_TOP);
      rsp_free = !rsp_valid_ff || !rsp_stall;

      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      pend_in      = 1'b0;
      upd_addr_in  = upd_addr_ff;
      clr_in       = clr_ff;
      size_in      = csr_write_enable ? csr_write_data : size_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = upd_addr_ff;
      ram_wr_data = ram_rd_data + CNT_W'(1);
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_dec[ADDR_W-1:0];

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               lo_in    = req_range_low;
               hi_in    = req_range_high;
               pos_in   = WALK_W'(req_range_high);
               acc_in   = '0;
               state_in = ST_QHI;
            end
         end
         ST_QHI, ST_QLO: begin
            // Read data arrives in the cycle after its address, so each step
            // folds in the previous read while it issues the next one.
            if (pend_ff) begin
               acc_in = (state_ff == ST_QHI) ? acc_ff + ram_rd_data
                                             : acc_ff - ram_rd_data;
            end
            if (pos_ff != '0) begin
               ram_rd_en = in_table;
               pend_in   = in_table;
               pos_in    = pos_ff - low_bit;
            end else if (state_ff == ST_QHI) begin
               pos_in   = (lo_ff == '0) ? '0 : WALK_W'(lo_ff) - WALK_W'(1);
               state_in = ST_QLO;
            end else begin
               pos_in   = WALK_W'(hi_ff);
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            // Read-modify-write; the upward walk never revisits an entry.
            if (pend_ff) begin
               ram_wr_en = 1'b1;
            end
            if ((pos_ff != '0) && (pos_ff <= limit)) begin
               ram_rd_en   = 1'b1;
               upd_addr_in = pos_dec[ADDR_W-1:0];
               pend_in     = 1'b1;
               pos_in      = pos_ff + low_bit;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         size_ff      <= frc_pkg::SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      pos_ff       <= pos_in;
      acc_ff       <= acc_in;
      upd_addr_ff  <= upd_addr_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_marked_count = rsp_count_ff;

   // The memory is written only by the clearing pass and the update walk.
   a_write_source : assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_CLEAR) || (state_ff == ST_UPD))
      else $error("tree written outside clearing or update");

   // An update write goes back to the entry read in the cycle before.
   a_rmw_addr : assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && state_ff == ST_UPD) |-> ram_wr_addr == $past(ram_rd_addr))
      else $error("update write address does not match its read");

   // A read and a write in the same cycle never meet at one entry.
   a_no_collide : assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> ram_wr_addr != ram_rd_addr)
      else $error("read and write collide on one tree entry");

   // An accepted word starts the upper prefix walk.
   a_accept_start : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_QHI)
      else $error("accepted word did not start the query");

   // A response appears only out of the output step.
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("response raised outside the output step");

endmodule

// ===== hw/rtl/frc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module frc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
